// ===== design/dqlpt_pkg.sv =====
// ----------------------------------------------------------------------------
// dqlpt_pkg
// Shared types, codes and floating-point helper functions for the per-tensor
// linear dequantizer.
// ----------------------------------------------------------------------------
package dqlpt_pkg;

  // Input format codes.
  localparam logic [3:0] FMT_U8       = 4'd0;
  localparam logic [3:0] FMT_I8       = 4'd1;
  localparam logic [3:0] FMT_U16      = 4'd2;
  localparam logic [3:0] FMT_I16      = 4'd3;
  localparam logic [3:0] FMT_I32      = 4'd4;
  localparam logic [3:0] FMT_E4M3FN   = 4'd5;
  localparam logic [3:0] FMT_E4M3FNUZ = 4'd6;
  localparam logic [3:0] FMT_E5M2     = 4'd7;
  localparam logic [3:0] FMT_E5M2FNUZ = 4'd8;
  localparam logic [3:0] FMT_I4       = 4'd9;
  localparam logic [3:0] FMT_U4       = 4'd10;
  localparam logic [3:0] FMT_I2       = 4'd11;
  localparam logic [3:0] FMT_U2       = 4'd12;
  localparam logic [3:0] FMT_F4E2M1   = 4'd13;

  // Configuration register indexes.
  localparam logic [1:0] REG_INPUT_FORMAT = 2'd0;
  localparam logic [1:0] REG_SCALE_VALUE  = 2'd1;
  localparam logic [1:0] REG_ZERO_POINT   = 2'd2;
  localparam logic [1:0] REG_OUTPUT_HALF  = 2'd3;

  localparam logic [31:0] QNAN32     = 32'h7FC0_0000;
  localparam logic [15:0] QNAN16     = 16'h7E00;
  localparam logic [31:0] SCALE_ONE  = 32'h3F80_0000;

  // Decoded element before normalization: value is mag * 2^eadj.
  typedef struct packed {
    logic              nan;
    logic              inf;
    logic              sign;
    logic [31:0]       mag;
    logic signed [7:0] eadj;
  } raw_t;

  // Aligned sum before normalization and rounding.
  typedef struct packed {
    logic        nan;
    logic        inf;
    logic        zero;
    logic        sign;
    logic [7:0]  exp;
    logic [27:0] sig;
  } sum_t;

  // Scale with subnormals already normalized.
  typedef struct packed {
    logic              nan;
    logic              inf;
    logic              zero;
    logic              sign;
    logic [23:0]       man;
    logic signed [9:0] exp;
  } scl_t;

  // Raw product before normalization and rounding.
  typedef struct packed {
    logic              nan;
    logic              inf;
    logic              zero;
    logic              sign;
    logic [47:0]       prod;
    logic signed [9:0] exp;
  } prod_t;

  function automatic raw_t mini_raw(input logic s, input logic [4:0] e,
                                    input logic [2:0] m, input int mb,
                                    input int bias, input logic is_nan,
                                    input logic is_inf);
    raw_t r;
    int   ev;
    r      = '0;
    ev     = (e == 5'd0) ? 1 : int'(e);
    r.nan  = is_nan;
    r.inf  = is_inf;
    r.sign = s;
    r.eadj = 8'(ev - bias - mb);
    r.mag  = (e == 5'd0) ? {29'b0, m} : ({29'b0, m} | (32'd1 << mb));
    return r;
  endfunction

  function automatic raw_t decode_raw(input logic [3:0] fmt, input logic [31:0] c);
    raw_t        r;
    logic [31:0] sx;
    r  = '0;
    sx = '0;
    unique case (fmt)
      FMT_U8:  r.mag = {24'b0, c[7:0]};
      FMT_I8: begin
        sx     = {{24{c[7]}}, c[7:0]};
        r.sign = c[7];
        r.mag  = c[7] ? -sx : sx;
      end
      FMT_U16: r.mag = {16'b0, c[15:0]};
      FMT_I16: begin
        sx     = {{16{c[15]}}, c[15:0]};
        r.sign = c[15];
        r.mag  = c[15] ? -sx : sx;
      end
      FMT_I32: begin
        r.sign = c[31];
        r.mag  = c[31] ? -c : c;
      end
      FMT_E4M3FN:
        r = mini_raw(c[7], {1'b0, c[6:3]}, c[2:0], 3, 7, c[6:0] == 7'h7F, 1'b0);
      FMT_E4M3FNUZ:
        r = mini_raw(c[7], {1'b0, c[6:3]}, c[2:0], 3, 8, c[7:0] == 8'h80, 1'b0);
      FMT_E5M2:
        r = mini_raw(c[7], c[6:2], {1'b0, c[1:0]}, 2, 15,
                     (c[6:2] == 5'h1F) && (c[1:0] != 2'b0),
                     (c[6:2] == 5'h1F) && (c[1:0] == 2'b0));
      FMT_E5M2FNUZ:
        r = mini_raw(c[7], c[6:2], {1'b0, c[1:0]}, 2, 16, c[7:0] == 8'h80, 1'b0);
      FMT_I4: begin
        sx     = {{28{c[3]}}, c[3:0]};
        r.sign = c[3];
        r.mag  = c[3] ? -sx : sx;
      end
      FMT_U4:  r.mag = {28'b0, c[3:0]};
      FMT_I2: begin
        sx     = {{30{c[1]}}, c[1:0]};
        r.sign = c[1];
        r.mag  = c[1] ? -sx : sx;
      end
      FMT_U2:  r.mag = {30'b0, c[1:0]};
      FMT_F4E2M1:
        r = mini_raw(c[3], {3'b0, c[2:1]}, {2'b0, c[0]}, 1, 1, 1'b0, 1'b0);
      default: r = '0;
    endcase
    return r;
  endfunction

  // Normalize a decoded element and round it to binary32.
  function automatic logic [31:0] raw_to_f32(input raw_t r);
    int          msb;
    int          ex;
    logic [31:0] nrm;
    logic        rnd;
    msb = 0;
    for (int i = 0; i < 32; i++) begin
      if (r.mag[i]) msb = i;
    end
    nrm = r.mag << (31 - msb);
    ex  = 127 + msb + int'(r.eadj);
    rnd = nrm[7] & ((|nrm[6:0]) | nrm[8]);
    if (r.nan) return QNAN32;
    if (r.inf) return {r.sign, 8'hFF, 23'b0};
    if (r.mag == 32'b0) return {r.sign, 31'b0};
    return {r.sign, 8'(ex), nrm[30:8]} + {31'b0, rnd};
  endfunction

  // Align and add two binary32 values. Inputs are never subnormal.
  function automatic sum_t add_align(input logic [31:0] a, input logic [31:0] b);
    sum_t        r;
    logic        a_nan, a_inf, b_nan, b_inf, sbig, stk;
    logic [23:0] mbig, msml;
    logic [7:0]  ebig, d;
    logic [26:0] ms27, sm;
    r     = '0;
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'b0);
    a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'b0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'b0);
    b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'b0);
    if (a[30:0] >= b[30:0]) begin
      mbig = (a[30:23] == 8'b0) ? 24'b0 : {1'b1, a[22:0]};
      msml = (b[30:23] == 8'b0) ? 24'b0 : {1'b1, b[22:0]};
      ebig = a[30:23];
      d    = a[30:23] - b[30:23];
      sbig = a[31];
    end else begin
      mbig = (b[30:23] == 8'b0) ? 24'b0 : {1'b1, b[22:0]};
      msml = (a[30:23] == 8'b0) ? 24'b0 : {1'b1, a[22:0]};
      ebig = b[30:23];
      d    = b[30:23] - a[30:23];
      sbig = b[31];
    end
    ms27 = {msml, 3'b0};
    if (d >= 8'd27) begin
      sm  = 27'b0;
      stk = |msml;
    end else begin
      sm  = ms27 >> d;
      stk = |(ms27 & ((27'd1 << d) - 27'd1));
    end
    sm = sm | {26'b0, stk};
    if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]))) begin
      r.nan = 1'b1;
    end else if (a_inf) begin
      r.inf  = 1'b1;
      r.sign = a[31];
    end else if (b_inf) begin
      r.inf  = 1'b1;
      r.sign = b[31];
    end else begin
      r.sig = (a[31] != b[31]) ? ({1'b0, mbig, 3'b0} - {1'b0, sm})
                               : ({1'b0, mbig, 3'b0} + {1'b0, sm});
      r.exp = ebig;
      if (r.sig == 28'b0) begin
        // Two zeros keep a negative sign only if both are negative.
        r.zero = 1'b1;
        r.sign = (a[30:0] == 31'b0 && b[30:0] == 31'b0) ? (a[31] & b[31]) : 1'b0;
      end else begin
        r.sign = sbig;
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] sum_round(input sum_t s);
    int          msb;
    int          ex;
    logic [26:0] t;
    logic        rnd;
    msb = 0;
    for (int i = 0; i < 27; i++) begin
      if (s.sig[i]) msb = i;
    end
    if (s.sig[27]) begin
      t  = {s.sig[27:2], s.sig[1] | s.sig[0]};
      ex = int'(s.exp) + 1;
    end else begin
      t  = s.sig[26:0] << (26 - msb);
      ex = int'(s.exp) - (26 - msb);
    end
    rnd = t[2] & (t[1] | t[0] | t[3]);
    if (s.nan) return QNAN32;
    if (s.inf) return {s.sign, 8'hFF, 23'b0};
    if (s.zero) return {s.sign, 31'b0};
    return {s.sign, 8'(ex), t[25:3]} + {31'b0, rnd};
  endfunction

  function automatic scl_t scale_prep(input logic [31:0] v);
    scl_t r;
    int   msb;
    r      = '0;
    r.sign = v[31];
    msb    = 0;
    for (int i = 0; i < 23; i++) begin
      if (v[i]) msb = i;
    end
    if (v[30:23] == 8'hFF) begin
      r.nan = (v[22:0] != 23'b0);
      r.inf = (v[22:0] == 23'b0);
    end else if (v[30:23] == 8'b0) begin
      if (v[22:0] == 23'b0) begin
        r.zero = 1'b1;
      end else begin
        r.man = {1'b0, v[22:0]} << (23 - msb);
        r.exp = 10'(msb - 149);
      end
    end else begin
      r.man = {1'b1, v[22:0]};
      r.exp = 10'(int'(v[30:23]) - 127);
    end
    return r;
  endfunction

  function automatic logic [31:0] mul_round(input prod_t q);
    int          ee;
    int          sh;
    logic [47:0] nq;
    logic [73:0] w;
    logic        rnd;
    nq = q.prod[47] ? q.prod : (q.prod << 1);
    ee = int'(q.exp) + 127 + (q.prod[47] ? 1 : 0);
    sh = 1 - ee;
    if (sh > 26) sh = 26;
    if (sh < 0) sh = 0;
    w  = {nq, 26'b0} >> sh;
    if (q.nan) return QNAN32;
    if (q.inf) return {q.sign, 8'hFF, 23'b0};
    if (q.zero) return {q.sign, 31'b0};
    if (ee >= 255) return {q.sign, 8'hFF, 23'b0};
    if (ee >= 1) begin
      rnd = nq[23] & ((|nq[22:0]) | nq[24]);
      return {q.sign, 8'(ee), nq[46:24]} + {31'b0, rnd};
    end
    // Subnormal result: the carry of rounding may reach the smallest normal.
    rnd = w[49] & ((|w[48:0]) | w[50]);
    return {q.sign, 8'h00, w[72:50]} + {31'b0, rnd};
  endfunction

  function automatic logic [15:0] to_half(input logic [31:0] b);
    logic        s;
    int          e;
    int          sh;
    logic [23:0] m, h, rem, hw;
    logic [12:0] rem13;
    logic [15:0] r;
    s     = b[31];
    e     = int'(b[30:23]) - 112;
    sh    = 14 - e;
    if (sh > 24) sh = 24;
    if (sh < 1) sh = 1;
    m     = {1'b1, b[22:0]};
    h     = m >> sh;
    rem   = m & ((24'd1 << sh) - 24'd1);
    hw    = 24'd1 << (sh - 1);
    rem13 = b[12:0];
    if (b[30:23] == 8'hFF) begin
      r = (b[22:0] != 23'b0) ? QNAN16 : {s, 5'h1F, 10'b0};
    end else if (e >= 31) begin
      r = {s, 5'h1F, 10'b0};
    end else if (e < -10) begin
      r = {s, 15'b0};
    end else if (e <= 0) begin
      if (rem > hw || (rem == hw && h[0])) h = h + 24'd1;
      r = {s, h[14:0]};
    end else begin
      r = {s, 5'(e), b[22:13]};
      if (rem13 > 13'h1000 || (rem13 == 13'h1000 && r[0])) r = r + 16'd1;
    end
    return r;
  endfunction

endpackage

// ===== design/dequantize_linear_per_tensor_core.sv =====
// A result is registered in each stage in turn and is on the output port once the
// last stage holds it; out_stall can hold it there before its output transfer.
// Throughput: one element per cycle unless the output stalls; the seven pipeline
// stages advance independently, so bubbles close up while the output is stalled.
// Reset: synchronous, active low; clears all stage valid bits and loads the
// register reset values (format u8, scale 1.0, zero point 0, float32 output).
// ----------------------------------------------------------------------------
// dequantize_linear_per_tensor_core
// Streams quantized element codes and returns (decode(x) - decode(zp)) * scale
// as float32 or float16 bits. Stages: decode, convert, align/add,
// normalize/round, multiply, product round, output format.
// ----------------------------------------------------------------------------
module dequantize_linear_per_tensor_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_element_code,
  input  logic        in_last_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_value_bits,
  output logic        out_last_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import dqlpt_pkg::*;

  logic [3:0]  fmt_r;
  logic [31:0] scale_r;
  logic [31:0] zp_r;
  logic        half_r;
  logic [31:0] zpf_r, zpf_nxt;
  scl_t        scl_r, scl_nxt;

  logic        v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r;
  logic        en1, en2, en3, en4, en5, en6, en7;
  logic        l1_r, l2_r, l3_r, l4_r, l5_r, l6_r, l7_r;
  raw_t        raw1_r, raw1_nxt;
  logic [31:0] x2_r, x2_nxt;
  sum_t        sum3_r, sum3_nxt;
  logic [31:0] d4_r, d4_nxt;
  prod_t       p5_r, p5_nxt;
  logic [31:0] f6_r, f6_nxt;
  logic [31:0] val7_r, val7_nxt;
  logic        d_nan, d_inf, d_zero;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r   <= FMT_U8;
      scale_r <= SCALE_ONE;
      zp_r    <= 32'b0;
      half_r  <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_INPUT_FORMAT: fmt_r   <= cfg_data[3:0];
        REG_SCALE_VALUE:  scale_r <= cfg_data;
        REG_ZERO_POINT:   zp_r    <= cfg_data;
        REG_OUTPUT_HALF:  half_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Zero point and scale are static between writes, so they are prepared
  // once here rather than in the element path.
  always_comb begin
    zpf_nxt = raw_to_f32(decode_raw(fmt_r, zp_r));
    scl_nxt = scale_prep(scale_r);
  end

  always_ff @(posedge clk) begin
    zpf_r <= zpf_nxt;
    scl_r <= scl_nxt;
  end

  // A stage loads when it is empty or its content moves on.
  assign en7      = !v7_r || !out_stall;
  assign en6      = !v6_r || en7;
  assign en5      = !v5_r || en6;
  assign en4      = !v4_r || en5;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_stall = !en1;

  always_comb begin
    raw1_nxt = decode_raw(fmt_r, in_element_code);
    x2_nxt   = raw_to_f32(raw1_r);
    sum3_nxt = add_align(x2_r, {~zpf_r[31], zpf_r[30:0]});
    d4_nxt   = sum_round(sum3_r);
    d_nan    = (d4_r[30:23] == 8'hFF) && (d4_r[22:0] != 23'b0);
    d_inf    = (d4_r[30:23] == 8'hFF) && (d4_r[22:0] == 23'b0);
    d_zero   = (d4_r[30:0] == 31'b0);
    p5_nxt.nan  = d_nan || scl_r.nan || (d_inf && scl_r.zero) || (d_zero && scl_r.inf);
    p5_nxt.inf  = d_inf || scl_r.inf;
    p5_nxt.zero = d_zero || scl_r.zero;
    p5_nxt.sign = d4_r[31] ^ scl_r.sign;
    p5_nxt.prod = {1'b1, d4_r[22:0]} * scl_r.man;
    p5_nxt.exp  = 10'(int'(d4_r[30:23]) - 127) + scl_r.exp;
    f6_nxt   = mul_round(p5_r);
    if (fmt_r > FMT_F4E2M1) begin
      val7_nxt = 32'b0;
    end else if (half_r) begin
      val7_nxt = {16'b0, to_half(f6_r)};
    end else begin
      val7_nxt = f6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
      if (en6) v6_r <= v5_r;
      if (en7) v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      raw1_r <= raw1_nxt;
      l1_r   <= in_last_in;
    end
    if (en2) begin
      x2_r <= x2_nxt;
      l2_r <= l1_r;
    end
    if (en3) begin
      sum3_r <= sum3_nxt;
      l3_r   <= l2_r;
    end
    if (en4) begin
      d4_r <= d4_nxt;
      l4_r <= l3_r;
    end
    if (en5) begin
      p5_r <= p5_nxt;
      l5_r <= l4_r;
    end
    if (en6) begin
      f6_r <= f6_nxt;
      l6_r <= l5_r;
    end
    if (en7) begin
      val7_r <= val7_nxt;
      l7_r   <= l6_r;
    end
  end

  assign out_valid      = v7_r;
  assign out_value_bits = val7_r;
  assign out_last_out   = l7_r;

`ifndef SYNTH
  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> v1_r)
    else $error("accepted element did not enter the first stage");

  a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> v1_r && v2_r && v7_r)
    else $error("input stalled while the pipeline has room");

  a_half_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && half_r |-> out_value_bits[31:16] == 16'b0)
    else $error("float16 result has upper bits set");

  a_nan_canonical: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !half_r && out_value_bits[30:23] == 8'hFF
      |-> out_value_bits[22:0] == 23'b0 || out_value_bits == QNAN32)
    else $error("float32 NaN result is not canonical");
`endif

endmodule
